// ===== hdl/text_console_cursor_engine_defines.svh =====
// assertion macros for the text console cursor engine checker
// needs clk and rst_n in the scope where the macros are used
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TCCE_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled during reset
`define TCCE_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/tcce_pkg.sv =====
// shared types, codes and constants of the text console cursor engine
// no dependencies
package tcce_pkg;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int TITLE_W = 8;
  localparam int TAB_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int CCOL_W  = 9;
  localparam int CROW_W  = 8;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int MAX_COLUMNS_DEF = 512;
  localparam int MAX_ROWS_DEF    = 256;

  localparam logic [COL_W-1:0]   COLUMNS_RST = 10'd80;
  localparam logic [ROW_W-1:0]   ROWS_RST    = 9'd25;
  localparam logic [TITLE_W-1:0] TITLE_RST   = 8'd1;
  localparam logic [TAB_W-1:0]   TAB_RST     = 7'd4;

  localparam logic [CHAR_W-1:0] CHR_NUL = 8'd0;
  localparam logic [CHAR_W-1:0] CHR_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CHR_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CHR_CR  = 8'd13;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TITLE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAB     = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_DRAW   = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [CCOL_W-1:0] cell_col;
    logic [CROW_W-1:0] cell_row;
    logic [CHAR_W-1:0] glyph;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0]       n;
    result_t          r0;
    result_t          r1;
    logic [COL_W-1:0] col_nxt;
    logic [ROW_W-1:0] row_nxt;
  } step_t;

  typedef struct packed {
    logic [COL_W-1:0]   columns;
    logic [ROW_W-1:0]   rows;
    logic [TITLE_W-1:0] title_rows;
    logic [TAB_W-1:0]   tab_size;
  } cfg_t;

endpackage

// ===== hdl/tcce_step.sv =====
// cursor update and result generation for one character word
// depends on tcce_pkg
module tcce_step
  import tcce_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  input  logic [COL_W-1:0]  col_q,
  input  logic [ROW_W-1:0]  row_q,
  input  cfg_t              cfg,
  output step_t             step
);

  logic [COL_W:0]   col_a;
  logic [COL_W:0]   tab_sum;
  logic [ROW_W:0]   row_a;
  logic [COL_W:0]   col_b;
  logic [ROW_W:0]   row_b;
  logic [ROW_W:0]   row_c;
  logic             ignore;
  logic             draw;
  logic             wrap;
  logic             act;
  logic             clr;
  logic [ROW_W-1:0] title_p1;
  result_t          res_draw;
  result_t          res_act;

  always_comb begin
    ignore  = 1'b0;
    draw    = 1'b0;
    col_a   = {1'b0, col_q};
    row_a   = {1'b0, row_q};
    tab_sum = {1'b0, col_q} + {{(COL_W+1-TAB_W){1'b0}}, cfg.tab_size};
    case (char_code)
      CHR_NUL: ignore = 1'b1;
      CHR_LF: begin
        col_a = '0;
        row_a = {1'b0, row_q} + {{ROW_W{1'b0}}, 1'b1};
      end
      CHR_CR: col_a = '0;
      CHR_TAB: begin
        // a zero tab size clears the column instead of applying the step mask
        if (cfg.tab_size == '0) begin
          col_a = '0;
        end else begin
          col_a = tab_sum & ~{{(COL_W+1-TAB_W){1'b0}}, cfg.tab_size - 7'd1};
        end
      end
      default: begin
        draw  = 1'b1;
        col_a = {1'b0, col_q} + {{COL_W{1'b0}}, 1'b1};
      end
    endcase
  end

  always_comb begin
    wrap     = col_a >= {1'b0, cfg.columns};
    col_b    = wrap ? '0 : col_a;
    row_b    = row_a + {{ROW_W{1'b0}}, wrap};
    act      = row_b >= {1'b0, cfg.rows};
    title_p1 = {1'b0, cfg.title_rows} + {{(ROW_W-1){1'b0}}, 1'b1};
    clr      = cfg.rows <= title_p1;
    row_c    = row_b;
    if (act) begin
      if (clr) begin
        col_b = '0;
        row_c = {{(ROW_W+1-TITLE_W){1'b0}}, cfg.title_rows};
      end else if (row_b <= {{ROW_W{1'b0}}, 1'b1}) begin
        row_c = {{ROW_W{1'b0}}, 1'b1};
      end else begin
        row_c = row_b - {{ROW_W{1'b0}}, 1'b1};
      end
    end
  end

  always_comb begin
    res_draw.command  = CMD_DRAW;
    res_draw.cell_col = col_q[CCOL_W-1:0];
    res_draw.cell_row = row_q[CROW_W-1:0];
    res_draw.glyph    = char_code;
    res_draw.last     = !act;

    res_act.command   = clr ? CMD_CLEAR : CMD_SCROLL;
    res_act.cell_col  = '0;
    res_act.cell_row  = '0;
    res_act.glyph     = '0;
    res_act.last      = 1'b1;

    if (ignore) begin
      step.n       = 2'd0;
      step.r0      = res_draw;
      step.r1      = res_act;
      step.col_nxt = col_q;
      step.row_nxt = row_q;
    end else begin
      step.n       = {1'b0, draw} + {1'b0, act};
      step.r0      = draw ? res_draw : res_act;
      step.r1      = res_act;
      step.col_nxt = col_b[COL_W-1:0];
      step.row_nxt = row_c[ROW_W-1:0];
    end
  end

endmodule

// ===== hdl/tcce_out_buf.sv =====
// two-entry result buffer: holds all results of one character word
// depends on tcce_pkg
module tcce_out_buf
  import tcce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic [1:0] load_n,
  input  result_t    load_r0,
  input  result_t    load_r1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  logic [1:0] cnt_r, cnt_nxt;
  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic       pop;

  assign out_valid = cnt_r != 2'd0;
  assign out_res   = slot0_r;
  assign pop       = out_valid && out_ready;
  // empty once this cycle's pop is done
  assign room      = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      cnt_nxt   = load_n;
      slot0_nxt = load_r0;
      slot1_nxt = load_r1;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// ===== hdl/text_console_cursor_engine.sv =====
// Text console cursor engine. Each accepted character word is held in an input
// register until it can advance, where the cursor logic turns it into zero, one or
// two results (draw, then scroll or clear) loaded into a two-entry result buffer.
// The first result is offered from the buffer register once its word advances. The
// block takes one character per cycle while results are taken each cycle; a character
// that yields two results fills both buffer entries, so the next character waits
// until the second of them is taken, and a stalled output holds back any word with
// results once the buffer holds one. Configuration writes take effect at once and
// are expected only while the block is idle.
// depends on tcce_pkg, tcce_step, tcce_out_buf
module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAR_W-1:0]     in_char_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CMD_W-1:0]      out_command,
  output logic [CCOL_W-1:0]     out_cell_col,
  output logic [CROW_W-1:0]     out_cell_row,
  output logic [CHAR_W-1:0]     out_glyph,
  output logic                  out_last,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg_r, cfg_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic [CHAR_W-1:0] s1_char_r, s1_char_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  step_t             step;
  logic              room;
  logic              advance;
  logic              load;
  result_t           out_res;

  tcce_step u_step (
    .char_code (s1_char_r),
    .col_q     (col_r),
    .row_q     (row_r),
    .cfg       (cfg_r),
    .step      (step)
  );

  assign advance  = s1_valid_r && ((step.n == 2'd0) || room);
  assign load     = advance && (step.n != 2'd0);
  assign in_ready = !s1_valid_r || advance;

  tcce_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_n    (step.n),
    .load_r0   (step.r0),
    .load_r1   (step.r1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_command  = out_res.command;
  assign out_cell_col = out_res.cell_col;
  assign out_cell_row = out_res.cell_row;
  assign out_glyph    = out_res.glyph;
  assign out_last     = out_res.last;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_char_nxt  = s1_char_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
      s1_char_nxt  = in_char_code;
    end
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      col_nxt = step.col_nxt;
      row_nxt = step.row_nxt;
    end
  end

  // oversized column and row counts saturate to the supported maximum
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_COLUMNS: begin
          if ({1'b0, cfg_data[COL_W-1:0]} > (COL_W+1)'(MAX_COLUMNS)) begin
            cfg_nxt.columns = COL_W'(MAX_COLUMNS);
          end else begin
            cfg_nxt.columns = cfg_data[COL_W-1:0];
          end
        end
        REG_ROWS: begin
          if ({1'b0, cfg_data[ROW_W-1:0]} > (ROW_W+1)'(MAX_ROWS)) begin
            cfg_nxt.rows = ROW_W'(MAX_ROWS);
          end else begin
            cfg_nxt.rows = cfg_data[ROW_W-1:0];
          end
        end
        REG_TITLE: cfg_nxt.title_rows = cfg_data[TITLE_W-1:0];
        REG_TAB:   cfg_nxt.tab_size   = cfg_data[TAB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      col_r            <= '0;
      row_r            <= '0;
      cfg_r.columns    <= COLUMNS_RST;
      cfg_r.rows       <= ROWS_RST;
      cfg_r.title_rows <= TITLE_RST;
      cfg_r.tab_size   <= TAB_RST;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      cfg_r      <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_char_r <= s1_char_nxt;
  end

endmodule

// ===== hdl/tcce_checker.sv =====
// port-level checks on the result channel of the cursor engine, bound to the top
// depends on tcce_pkg and text_console_cursor_engine_defines.svh
`include "text_console_cursor_engine_defines.svh"

module tcce_checker
  import tcce_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CMD_W-1:0]  out_command,
  input logic [CCOL_W-1:0] out_cell_col,
  input logic [CROW_W-1:0] out_cell_row,
  input logic [CHAR_W-1:0] out_glyph,
  input logic              out_last
);

  logic                                 is_draw;
  logic                                 stall;
  logic                                 act_word;
  logic                                 cell_zero;
  logic                                 draw_split;
  logic [CMD_W+CCOL_W+CROW_W+CHAR_W:0] out_word;

  assign is_draw    = out_command == CMD_DRAW;
  assign stall      = out_valid && !out_ready;
  assign act_word   = out_valid && !is_draw;
  assign cell_zero  = out_cell_col == '0 && out_cell_row == '0 && out_glyph == '0;
  assign draw_split = out_valid && out_ready && is_draw && !out_last;
  assign out_word   = {out_command, out_cell_col, out_cell_row, out_glyph, out_last};

  `TCCE_ASSERT_NXT(a_out_hold, stall, out_valid && $stable(out_word), "stalled result word changed")

  `TCCE_ASSERT_NOW(a_act_fields_zero, act_word, cell_zero, "scroll or clear has cell fields")

  `TCCE_ASSERT_NOW(a_act_is_last, act_word, out_last, "scroll or clear word not marked last")

  `TCCE_ASSERT_NXT(a_draw_followup, draw_split, act_word, "split draw not followed by scroll or clear")

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (.*);

// ===== tb/tcce_command_checker.sv =====
// cursor and command predictor for the text console cursor engine, plus the result compare
// depends on tcce_pkg; watches the char, result and register ports of the engine
`timescale 1ns / 1ps

module tcce_command_checker
  import tcce_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [CMD_W-1:0]      out_command,
  input  logic [CCOL_W-1:0]     out_cell_col,
  input  logic [CROW_W-1:0]     out_cell_row,
  input  logic [CHAR_W-1:0]     out_glyph,
  input  logic                  out_last,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           outstanding,
  output int unsigned           failures,
  output int unsigned           n_draws,
  output int unsigned           n_scrolls,
  output int unsigned           n_clears
);

  // screen geometry as the engine should hold it
  logic [31:0] scr_columns;
  logic [31:0] scr_rows;
  logic [31:0] scr_title;
  logic [31:0] scr_tab;

  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;

  result_t     expected_cmds[$];
  int unsigned fail_cnt = 0;
  int unsigned draw_cnt = 0;
  int unsigned scroll_cnt = 0;
  int unsigned clear_cnt = 0;

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_COLUMNS: begin
        scr_columns = (data[COL_W-1:0] > MAX_COLUMNS) ? MAX_COLUMNS : data[COL_W-1:0];
      end
      REG_ROWS: begin
        scr_rows = (data[ROW_W-1:0] > MAX_ROWS) ? MAX_ROWS : data[ROW_W-1:0];
      end
      REG_TITLE: scr_title = data[TITLE_W-1:0];
      REG_TAB:   scr_tab = data[TAB_W-1:0];
      default: ;
    endcase
  endfunction

  // one char word: draw first, then column wrap, then at most one scroll or clear
  function automatic void advance_cursor(input logic [CHAR_W-1:0] ch);
    logic [31:0] col;
    logic [31:0] row;
    result_t     made[2];
    int          n;
    col = cur_col;
    row = cur_row;
    n = 0;
    if (ch == CHR_NUL) return;
    case (ch)
      CHR_LF: begin
        col = 0;
        row = row + 1;
      end
      CHR_CR: col = 0;
      CHR_TAB: col = (col + scr_tab) & ~(scr_tab - 32'd1);
      default: begin
        made[n] = '{command: CMD_DRAW, cell_col: col[CCOL_W-1:0],
                    cell_row: row[CROW_W-1:0], glyph: ch, last: 1'b0};
        n++;
        col = col + 1;
      end
    endcase
    if (col >= scr_columns) begin
      col = 0;
      row = row + 1;
    end
    if (row >= scr_rows) begin
      if (scr_rows <= scr_title + 1) begin
        made[n] = '{command: CMD_CLEAR, cell_col: '0, cell_row: '0, glyph: '0, last: 1'b0};
        n++;
        col = 0;
        row = scr_title;
      end else begin
        made[n] = '{command: CMD_SCROLL, cell_col: '0, cell_row: '0, glyph: '0, last: 1'b0};
        n++;
        row = (row <= 1) ? 32'd1 : row - 1;
      end
    end
    cur_col = col[COL_W-1:0];
    cur_row = row[ROW_W-1:0];
    for (int i = 0; i < n; i++) begin
      made[i].last = (i == n - 1);
      expected_cmds.push_back(made[i]);
    end
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_cnt++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (expected_cmds.size() == 0) begin
      $error("unexpected result word: command %0d", out_command);
      fail_cnt++;
      return;
    end
    want = expected_cmds.pop_front();
    compare_field("command", want.command, out_command);
    compare_field("cell_col", want.cell_col, out_cell_col);
    compare_field("cell_row", want.cell_row, out_cell_row);
    compare_field("glyph", want.glyph, out_glyph);
    compare_field("last", want.last, out_last);
    case (want.command)
      CMD_DRAW:   draw_cnt++;
      CMD_SCROLL: scroll_cnt++;
      default:    clear_cnt++;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      scr_columns = COLUMNS_RST;
      scr_rows = ROWS_RST;
      scr_title = TITLE_RST;
      scr_tab = TAB_RST;
      cur_col = '0;
      cur_row = '0;
      expected_cmds.delete();
    end else begin
      if (cfg_wr_en) apply_write(cfg_index, cfg_data);
      // pop before push so an early result is never matched to the word just taken
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) advance_cursor(in_char_code);
    end
    outstanding <= expected_cmds.size();
    failures <= fail_cnt;
    n_draws <= draw_cnt;
    n_scrolls <= scroll_cnt;
    n_clears <= clear_cnt;
  end

endmodule

// ===== tb/tb_text_console_cursor_engine.sv =====
// top of the text console cursor engine testbench: clock, reset, char and register stimulus
// depends on tcce_pkg, text_console_cursor_engine and tcce_command_checker
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  localparam int ITEMS          = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_char_code = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CMD_W-1:0]      out_command;
  logic [CCOL_W-1:0]     out_cell_col;
  logic [CROW_W-1:0]     out_cell_row;
  logic [CHAR_W-1:0]     out_glyph;
  logic                  out_last;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned outstanding;
  int unsigned failures;
  int unsigned n_draws;
  int unsigned n_scrolls;
  int unsigned n_clears;

  int unsigned n_chars;
  int unsigned n_ignored;
  int unsigned n_settings;
  int unsigned quiet_cycles;
  idle_mode_t  tx_mode = IDLE_SOME;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_console_cursor_engine DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_command  (out_command),
    .out_cell_col (out_cell_col),
    .out_cell_row (out_cell_row),
    .out_glyph    (out_glyph),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  tcce_command_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_command  (out_command),
    .out_cell_col (out_cell_col),
    .out_cell_row (out_cell_row),
    .out_glyph    (out_glyph),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .failures     (failures),
    .n_draws      (n_draws),
    .n_scrolls    (n_scrolls),
    .n_clears     (n_clears)
  );

  function automatic int pick_gap(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 19)) : 0;
      default:   return $urandom_range(0, 19);
    endcase
  endfunction

  // mostly text with line controls, some ignored bytes and raw noise
  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(32, 126);
    if (r < 65) return CHR_LF;
    if (r < 70) return CHR_CR;
    if (r < 78) return CHR_TAB;
    if (r < 81) return CHR_NUL;
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_value(input int unsigned typical_hi,
                                                       input logic [CFG_DATA_W-1:0] extreme);
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1023);
      1:       return extreme;
      default: return $urandom_range(0, typical_hi);
    endcase
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] ch);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_mode = idle_mode_t'($urandom_range(0, 2));
    gap = pick_gap(tx_mode);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_char_code <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (ch == CHR_NUL) n_ignored++;
    else n_chars++;
  endtask

  // hold off the sender until every expected result word is out and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic set_screen(input logic [CFG_DATA_W-1:0] cols_v, rows_v, title_v, tab_v);
    settle();
    write_reg(REG_COLUMNS, cols_v);
    write_reg(REG_ROWS, rows_v);
    write_reg(REG_TITLE, title_v);
    write_reg(REG_TAB, tab_v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  initial begin : result_sink
    idle_mode_t mode;
    int         gap;
    mode = IDLE_HEAVY;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) mode = idle_mode_t'($urandom_range(0, 2));
      gap = pick_gap(mode);
      if (gap != 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, outstanding);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] rows_v;
    int                    phase_len;
    int                    i;
    n_chars = 0;
    n_ignored = 0;
    n_settings = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry: drawn bytes at the code extremes, each control byte, an ignored byte
    send_char(8'h41);
    send_char(8'hFF);
    send_char(8'h01);
    send_char(CHR_TAB);
    send_char(CHR_CR);
    send_char(CHR_LF);
    send_char(CHR_NUL);
    send_char(8'h80);
    // oversized sizes saturate, title fills the screen, odd tab stop
    set_screen(10'd1023, 10'd511, 10'd255, 10'd127);
    send_char(CHR_TAB);
    send_char(8'h7E);
    send_char(CHR_LF);
    // zero columns and zero rows, tab of zero
    set_screen(10'd0, 10'd0, 10'd0, 10'd0);
    send_char(8'h61);
    send_char(CHR_LF);
    send_char(CHR_TAB);
    // narrow screen: wrap, then a tab past the edge forces a scroll
    set_screen(10'd3, 10'd4, 10'd2, 10'd64);
    send_char(8'h71);
    send_char(8'h72);
    send_char(8'h73);
    send_char(CHR_LF);
    send_char(CHR_LF);
    send_char(CHR_TAB);
    // screen shrunk under the cursor: one scroll per word only
    set_screen(10'd3, 10'd2, 10'd0, 10'd4);
    send_char(8'h7A);
    send_char(8'h7A);
    // rows just one past the title: clear instead of scroll
    set_screen(10'd5, 10'd3, 10'd2, 10'd4);
    send_char(CHR_LF);
    send_char(CHR_LF);

    while (n_chars < ITEMS) begin
      rows_v = pick_value(8, 10'd256);
      set_screen(pick_value(12, 10'd512), rows_v, pick_value(rows_v + 1, 10'd255),
                 pick_value(8, 10'd64));
      phase_len = $urandom_range(40, 200);
      for (i = 0; i < phase_len && n_chars < ITEMS; i++) begin
        send_char(pick_char());
        if ($urandom_range(0, 149) == 0) settle();
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d chars and %0d zero bytes over %0d screen geometries",
             n_chars, n_ignored, n_settings);
    $display("checked %0d draws, %0d scrolls, %0d clears", n_draws, n_scrolls, n_clears);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
